>>> rtl/owrs_pkg.sv
// ----------------------------------------------------------------------------
// owrs_pkg - shared types for the two-device rom search
// operation codes, state and result records, bit-serial crc8 helper
// ----------------------------------------------------------------------------
package owrs_pkg;

	localparam int unsigned ROM_BITS = 64;
	localparam int unsigned POS_W    = $clog2(ROM_BITS);
	localparam int unsigned FAM_W    = 7;
	localparam logic [7:0]  CRC_POLY = 8'h8C;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_RESET = 2'd1,
		OP_BITS  = 2'd2,
		OP_RSVD  = 2'd3
	} owrs_op_t;

	typedef struct packed {
		logic                pass_number;
		logic                conflict_seen;
		logic                in_pass;
		logic                finished;
		logic [POS_W-1:0]    bit_position;
		logic [ROM_BITS-1:0] rom_shift;
		logic [7:0]          crc_value;
		logic [1:0]          device_count;
	} owrs_state_t;

	// state after reset: everything clear, search ended
	localparam owrs_state_t STATE_RESET = {
		1'b0, 1'b0, 1'b0, 1'b1, {POS_W{1'b0}}, {ROM_BITS{1'b0}}, 8'h00, 2'd0
	};

	typedef struct packed {
		logic                write_bit;
		logic                write_valid;
		logic [ROM_BITS-1:0] rom_id;
		logic                rom_valid;
		logic                rom_slot;
		logic [1:0]          found_count;
		logic                need_reset;
		logic                search_done;
		logic                order_error;
	} owrs_result_t;

	// one step of the reflected crc8
	function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic din);
		logic       fb;
		logic [7:0] nxt;
		fb  = crc[0] ^ din;
		nxt = {1'b0, crc[7:1]};
		if (fb) begin
			nxt = nxt ^ CRC_POLY;
		end
		return nxt;
	endfunction

endpackage

>>> rtl/owrs_cmd_if.sv
// ----------------------------------------------------------------------------
// owrs_cmd_if - request channel of the rom search
// valid/ready handshake carrying one operation and its bus bits
// ----------------------------------------------------------------------------
interface owrs_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic       presence;
	logic       first_bit;
	logic       second_bit;

	modport source (
		output valid, operation, presence, first_bit, second_bit,
		input  ready
	);
	modport sink (
		input  valid, operation, presence, first_bit, second_bit,
		output ready
	);
endinterface

>>> rtl/owrs_rsp_if.sv
// ----------------------------------------------------------------------------
// owrs_rsp_if - result channel of the rom search
// valid/ready handshake carrying the direction bit, rom id and status
// ----------------------------------------------------------------------------
interface owrs_rsp_if;
	logic        valid;
	logic        ready;
	logic        write_bit;
	logic        write_valid;
	logic [63:0] rom_id;
	logic        rom_valid;
	logic        rom_slot;
	logic [1:0]  found_count;
	logic        need_reset;
	logic        search_done;
	logic        order_error;

	modport source (
		output valid, write_bit, write_valid, rom_id, rom_valid, rom_slot,
		       found_count, need_reset, search_done, order_error,
		input  ready
	);
	modport sink (
		input  valid, write_bit, write_valid, rom_id, rom_valid, rom_slot,
		       found_count, need_reset, search_done, order_error,
		output ready
	);
endinterface

>>> rtl/owrs_step.sv
// ----------------------------------------------------------------------------
// owrs_step - next-state and result logic for one request
// purely combinational, evaluated once per accepted request
// ----------------------------------------------------------------------------
module owrs_step (
	input  owrs_pkg::owrs_state_t               cur,
	input  logic [1:0]                          operation,
	input  logic                                presence,
	input  logic                                first_bit,
	input  logic                                second_bit,
	input  logic [owrs_pkg::FAM_W-1:0]          family_code,
	output owrs_pkg::owrs_state_t               nxt,
	output owrs_pkg::owrs_result_t              res
);

	logic                             dir;
	logic [7:0]                       crc_nxt;
	logic [owrs_pkg::ROM_BITS-1:0]    shift_nxt;
	logic                             last_bit;

	assign dir       = (first_bit != second_bit) ? first_bit : cur.pass_number;
	assign crc_nxt   = owrs_pkg::crc_bit(cur.crc_value, dir);
	// lsb first: new bit enters at the top, first bit lands in bit 0
	assign shift_nxt = {dir, cur.rom_shift[owrs_pkg::ROM_BITS-1:1]};
	assign last_bit  = (cur.bit_position == {owrs_pkg::POS_W{1'b1}});

	always_comb begin
		nxt = cur;
		res = '0;
		case (owrs_pkg::owrs_op_t'(operation))
			owrs_pkg::OP_START: begin
				nxt.pass_number   = 1'b0;
				nxt.conflict_seen = 1'b0;
				nxt.in_pass       = 1'b0;
				nxt.finished      = 1'b0;
				nxt.bit_position  = '0;
				nxt.rom_shift     = '0;
				nxt.crc_value     = '0;
				nxt.device_count  = 2'd0;
			end
			owrs_pkg::OP_RESET: begin
				if (cur.finished || cur.in_pass) begin
					res.order_error = 1'b1;
				end else if (!presence) begin
					nxt.finished = 1'b1;
				end else begin
					nxt.in_pass      = 1'b1;
					nxt.bit_position = '0;
					nxt.rom_shift    = '0;
					nxt.crc_value    = '0;
				end
			end
			owrs_pkg::OP_BITS: begin
				if (!cur.in_pass) begin
					res.order_error = 1'b1;
				end else if (first_bit && second_bit) begin
					// nobody answered: abort
					nxt.in_pass  = 1'b0;
					nxt.finished = 1'b1;
				end else begin
					if (first_bit == second_bit) begin
						nxt.conflict_seen = 1'b1;
					end
					res.write_bit    = dir;
					res.write_valid  = 1'b1;
					nxt.rom_shift    = shift_nxt;
					nxt.crc_value    = crc_nxt;
					nxt.bit_position = cur.bit_position + 1'b1;
					if (last_bit) begin
						nxt.in_pass      = 1'b0;
						nxt.bit_position = '0;
						if (crc_nxt == 8'h00 &&
						    shift_nxt[owrs_pkg::FAM_W-1:0] == family_code) begin
							res.rom_id    = shift_nxt;
							res.rom_valid = 1'b1;
							res.rom_slot  = cur.pass_number;
							if (cur.device_count != 2'd2) begin
								nxt.device_count = cur.device_count + 2'd1;
							end
							if (!cur.pass_number && (cur.conflict_seen ||
							    first_bit == second_bit)) begin
								nxt.pass_number = 1'b1;
							end else begin
								nxt.finished = 1'b1;
							end
						end else begin
							nxt.finished = 1'b1;
						end
					end
				end
			end
			default: begin
				res.order_error = 1'b1;
			end
		endcase
		res.found_count = nxt.device_count;
		res.need_reset  = !nxt.finished && !nxt.in_pass;
		res.search_done = nxt.finished;
	end

endmodule

>>> rtl/owrs_rsp_reg.sv
// ----------------------------------------------------------------------------
// owrs_rsp_reg - result register in front of the result channel
// holds one result, reloads in the cycle it is taken
// ----------------------------------------------------------------------------
module owrs_rsp_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  owrs_pkg::owrs_result_t data,
	output logic                   room,
	owrs_rsp_if.source             rsp
);

	logic                   valid_q;
	owrs_pkg::owrs_result_t data_q;

	assign room = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.write_bit   = data_q.write_bit;
	assign rsp.write_valid = data_q.write_valid;
	assign rsp.rom_id      = data_q.rom_id;
	assign rsp.rom_valid   = data_q.rom_valid;
	assign rsp.rom_slot    = data_q.rom_slot;
	assign rsp.found_count = data_q.found_count;
	assign rsp.need_reset  = data_q.need_reset;
	assign rsp.search_done = data_q.search_done;
	assign rsp.order_error = data_q.order_error;

endmodule

>>> rtl/onewire_two_device_rom_search.sv
// ----------------------------------------------------------------------------
// onewire_two_device_rom_search - search rom engine for up to two devices
// tracks a search rom sequence one bus event at a time
// ----------------------------------------------------------------------------
// Every request gives exactly one result. A request is taken each cycle the
// result register is empty or its content is being taken, so the sustained
// rate is one request per clock; the result is registered and appears in the
// cycle after the request is taken. The whole update of the search state
// (direction choice, rom shift, one crc8 step, end-of-pass checks) is one short
// combinational step between the state registers and the result register.
// Usage: send a start request, then a reset outcome carrying the presence
// flag, then 64 bit pairs, answering each with write_bit when write_valid
// is set. need_reset asks for another bus reset before the next pass;
// search_done means found_count is final. family_code must be written only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module onewire_two_device_rom_search (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       family_code_wr_en,
	input  logic [6:0] family_code_wr_data,
	owrs_cmd_if.sink   cmd,
	owrs_rsp_if.source rsp
);

	// search state, reset leaves the search ended
	owrs_pkg::owrs_state_t  state_q;
	owrs_pkg::owrs_state_t  state_nxt;
	owrs_pkg::owrs_result_t result;
	logic [6:0]             family_code_q;
	logic                   room;
	logic                   accept;

	// a request goes in when the result register has room
	assign cmd.ready = room;
	assign accept    = cmd.valid && room;

	// family code register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			family_code_q <= '0;
		end else if (family_code_wr_en) begin
			family_code_q <= family_code_wr_data;
		end
	end

	// next state and result for the request on the channel
	owrs_step u_step (
		.cur         (state_q),
		.operation   (cmd.operation),
		.presence    (cmd.presence),
		.first_bit   (cmd.first_bit),
		.second_bit  (cmd.second_bit),
		.family_code (family_code_q),
		.nxt         (state_nxt),
		.res         (result)
	);

	// state advances only on an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= owrs_pkg::STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// result register decouples the result channel
	owrs_rsp_reg u_rsp_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.data   (result),
		.room   (room),
		.rsp    (rsp)
	);

endmodule

>>> tb/sv/owrs_search_checker.sv
// ----------------------------------------------------------------------------
// owrs_search_checker - result predictor and scoreboard for the rom search
// tracks the search state from accepted requests and compares every result
// ----------------------------------------------------------------------------
module owrs_search_checker
	import owrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       family_code_wr_en,
	input  logic [6:0] family_code_wr_data,
	owrs_cmd_if        cmd,
	owrs_rsp_if        rsp,
	output int         fail_count,
	output int         results_owed
);

	localparam int PRINT_LIMIT = 200;

	// predicted search state
	logic                pass_sel;
	logic                conflict_hit;
	logic                pass_active;
	logic                search_over;
	logic [6:0]          bit_cnt;
	logic [ROM_BITS-1:0] id_shift;
	logic [7:0]          crc_acc;
	logic [1:0]          devices_found;
	logic [FAM_W-1:0]    family_reg;

	owrs_result_t predicted_results[$];
	owrs_result_t got_r;
	owrs_result_t want_r;
	int           results_seen;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		fail_count++;
		if (fail_count <= PRINT_LIMIT) begin
			$display("mismatch on %s at result %0d: got %h, expected %h",
				what, results_seen, got, want);
		end
	endtask

	// next search state and the result of one request
	function automatic owrs_result_t search_step(input logic [1:0] op_code,
			input logic pres, input logic id_bit, input logic cmp_bit);
		owrs_result_t r;
		logic         dir;
		r = '0;
		case (owrs_op_t'(op_code))
			OP_START: begin
				pass_sel      = 1'b0;
				conflict_hit  = 1'b0;
				pass_active   = 1'b0;
				search_over   = 1'b0;
				bit_cnt       = '0;
				id_shift      = '0;
				crc_acc       = '0;
				devices_found = '0;
			end
			OP_RESET: begin
				if (search_over || pass_active) begin
					r.order_error = 1'b1;
				end else if (!pres) begin
					search_over = 1'b1;
				end else begin
					pass_active = 1'b1;
					bit_cnt     = '0;
					id_shift    = '0;
					crc_acc     = '0;
				end
			end
			OP_BITS: begin
				if (!pass_active) begin
					r.order_error = 1'b1;
				end else if (id_bit && cmp_bit) begin
					pass_active = 1'b0;
					search_over = 1'b1;
				end else begin
					if (id_bit != cmp_bit) begin
						dir = id_bit;
					end else begin
						conflict_hit = 1'b1;
						dir          = pass_sel;
					end
					r.write_bit   = dir;
					r.write_valid = 1'b1;
					if (dir) begin
						id_shift[bit_cnt[5:0]] = 1'b1;
					end
					crc_acc = {1'b0, crc_acc[7:1]} ^ ((crc_acc[0] ^ dir) ? CRC_POLY : 8'h00);
					bit_cnt = bit_cnt + 7'd1;
					if (bit_cnt == 7'(ROM_BITS)) begin
						pass_active = 1'b0;
						bit_cnt     = '0;
						if (crc_acc == 8'h00 && id_shift[FAM_W-1:0] == family_reg) begin
							r.rom_id    = id_shift;
							r.rom_valid = 1'b1;
							r.rom_slot  = pass_sel;
							if (devices_found < 2'd2) begin
								devices_found = devices_found + 2'd1;
							end
							if (!pass_sel && conflict_hit) begin
								pass_sel = 1'b1;
							end else begin
								search_over = 1'b1;
							end
						end else begin
							search_over = 1'b1;
						end
					end
				end
			end
			default: begin
				r.order_error = 1'b1;
			end
		endcase
		r.found_count = devices_found;
		r.need_reset  = !search_over && !pass_active;
		r.search_done = search_over;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_sel      = 1'b0;
			conflict_hit  = 1'b0;
			pass_active   = 1'b0;
			search_over   = 1'b1;
			bit_cnt       = '0;
			id_shift      = '0;
			crc_acc       = '0;
			devices_found = '0;
			family_reg    = '0;
			predicted_results.delete();
			fail_count    = 0;
			results_seen  = 0;
			results_owed <= 0;
		end else begin
			if (family_code_wr_en) begin
				family_reg = family_code_wr_data;
			end
			if (cmd.valid && cmd.ready) begin
				predicted_results.push_back(search_step(cmd.operation, cmd.presence,
					cmd.first_bit, cmd.second_bit));
			end
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (predicted_results.size() == 0) begin
					report_mismatch("result with nothing outstanding", rsp.rom_id, '0);
				end else begin
					want_r = predicted_results.pop_front();
					got_r  = '{rsp.write_bit, rsp.write_valid, rsp.rom_id, rsp.rom_valid,
						rsp.rom_slot, rsp.found_count, rsp.need_reset, rsp.search_done,
						rsp.order_error};
					if (got_r.write_bit !== want_r.write_bit)
						report_mismatch("write_bit", 64'(got_r.write_bit),
							64'(want_r.write_bit));
					if (got_r.write_valid !== want_r.write_valid)
						report_mismatch("write_valid", 64'(got_r.write_valid),
							64'(want_r.write_valid));
					if (got_r.rom_id !== want_r.rom_id)
						report_mismatch("rom_id", got_r.rom_id, want_r.rom_id);
					if (got_r.rom_valid !== want_r.rom_valid)
						report_mismatch("rom_valid", 64'(got_r.rom_valid),
							64'(want_r.rom_valid));
					if (got_r.rom_slot !== want_r.rom_slot)
						report_mismatch("rom_slot", 64'(got_r.rom_slot),
							64'(want_r.rom_slot));
					if (got_r.found_count !== want_r.found_count)
						report_mismatch("found_count", 64'(got_r.found_count),
							64'(want_r.found_count));
					if (got_r.need_reset !== want_r.need_reset)
						report_mismatch("need_reset", 64'(got_r.need_reset),
							64'(want_r.need_reset));
					if (got_r.search_done !== want_r.search_done)
						report_mismatch("search_done", 64'(got_r.search_done),
							64'(want_r.search_done));
					if (got_r.order_error !== want_r.order_error)
						report_mismatch("order_error", 64'(got_r.order_error),
							64'(want_r.order_error));
				end
			end
			results_owed <= predicted_results.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench top for the two-device rom search
// emulates up to two devices on the bus, drives search sequences, noise and
// config changes under varying idle and stall patterns; verdict from checker
// ----------------------------------------------------------------------------
module tb;
	import owrs_pkg::*;

	localparam int PHASE_REQUESTS = 330;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int QUIET_LIMIT    = 4000;
	localparam int DRAIN_CYCLES   = 10;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       family_code_wr_en;
	logic [6:0] family_code_wr_data;

	owrs_cmd_if cmd ();
	owrs_rsp_if rsp ();

	int fail_count;
	int results_owed;

	// stimulus knobs, percent of cycles spent idle or stalled
	int  send_idle_pct = 0;
	int  stall_pct     = 0;
	bit  holdoff_pending = 1'b0;
	bit  holdoff_done    = 1'b0;
	int  requests_sent   = 0;
	int  quiet_cycles    = 0;

	// devices currently on the emulated bus
	logic [6:0]  cur_family = '0;
	logic [63:0] bus_rom [2];
	logic [1:0]  bus_mask;

	onewire_two_device_rom_search u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.family_code_wr_en   (family_code_wr_en),
		.family_code_wr_data (family_code_wr_data),
		.cmd                 (cmd),
		.rsp                 (rsp)
	);

	owrs_search_checker u_chk (
		.clk                 (clk),
		.arst_n              (arst_n),
		.family_code_wr_en   (family_code_wr_en),
		.family_code_wr_data (family_code_wr_data),
		.cmd                 (cmd),
		.rsp                 (rsp),
		.fail_count          (fail_count),
		.results_owed        (results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: ends the run if no request and no result moves for too long
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("onewire_two_device_rom_search test failed");
				$finish;
			end
		end
	end

	// result side: random stalls, plus one long hold-off so that the result
	// register stays full and the request side backs up behind it
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_pending) begin
				holdoff_pending = 1'b0;
				rsp.ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end else begin
				rsp.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// random single bit and random operation code
	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	function automatic logic [1:0] rand_op();
		return 2'($urandom_range(3));
	endfunction

	// offer one request, with random idle cycles in front, and wait for it
	// to be taken; valid gets exactly one assignment per clock edge
	task automatic send_request(input logic [1:0] op, input logic pres,
			input logic id_bit, input logic cmp_bit);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid      <= 1'b1;
		cmd.operation  <= op;
		cmd.presence   <= pres;
		cmd.first_bit  <= id_bit;
		cmd.second_bit <= cmp_bit;
		do @(posedge clk); while (!cmd.ready);
		requests_sent++;
	endtask

	// family code change, only once every outstanding result is back
	task automatic write_family(input logic [6:0] fam);
		do @(posedge clk); while (results_owed != 0);
		repeat (2) @(posedge clk);
		family_code_wr_en   <= 1'b1;
		family_code_wr_data <= fam;
		cur_family = fam;
		@(posedge clk);
		family_code_wr_en   <= 1'b0;
	endtask

	// rom id with the current family and a valid crc byte, or one that
	// breaks exactly one of the two checks
	function automatic logic [63:0] make_rom(input bit good);
		logic [63:0] r;
		logic [7:0]  c;
		int          flaw;
		r    = {$urandom, $urandom};
		flaw = good ? 0 : $urandom_range(1, 2);
		r[6:0] = cur_family ^ ((flaw == 1) ? 7'($urandom_range(1, 127)) : 7'd0);
		c = 8'h00;
		for (int i = 0; i < 56; i++) begin
			c = {1'b0, c[7:1]} ^ ((c[0] ^ r[i]) ? 8'h8C : 8'h00);
		end
		r[63:56] = c ^ ((flaw == 2) ? 8'($urandom_range(1, 255)) : 8'd0);
		return r;
	endfunction

	// one search pass on the emulated bus: the read pair is the wired-and
	// of the id bit and its complement over the devices still taking part;
	// a pass can be cut short (restart) or forced into the both-ones abort
	task automatic run_pass(input bit pass_no, input int stop_at, input int abort_at,
			output bit conflict);
		logic [1:0] alive;
		logic       id_bit;
		logic       cmp_bit;
		logic       dir;
		alive    = bus_mask;
		conflict = 1'b0;
		for (int i = 0; i < ROM_BITS; i++) begin
			if (i == stop_at) return;
			id_bit  = 1'b1;
			cmp_bit = 1'b1;
			for (int d = 0; d < 2; d++) begin
				if (alive[d]) begin
					id_bit  &= bus_rom[d][i];
					cmp_bit &= ~bus_rom[d][i];
				end
			end
			if (i == abort_at) begin
				id_bit  = 1'b1;
				cmp_bit = 1'b1;
			end
			send_request(OP_BITS, rand_bit(), id_bit, cmp_bit);
			if (id_bit && cmp_bit) return;
			if (id_bit != cmp_bit) begin
				dir = id_bit;
			end else begin
				dir      = pass_no;
				conflict = 1'b1;
			end
			for (int d = 0; d < 2; d++) begin
				if (bus_rom[d][i] != dir) alive[d] = 1'b0;
			end
		end
	endtask

	// one random scenario: mostly complete searches with random ids, the
	// rest failed checks, empty bus, aborts, restarts and plain noise
	task automatic run_random_search();
		int  kind;
		bit  conflict;
		bit  good0;
		bit  good1;
		kind = $urandom_range(99);
		if (kind >= 90) begin
			repeat ($urandom_range(1, 8)) begin
				send_request(rand_op(), rand_bit(), rand_bit(), rand_bit());
			end
			return;
		end
		send_request(OP_START, rand_bit(), rand_bit(), rand_bit());
		// no presence pulse, or presence with nobody answering the search
		if (kind >= 68 && kind < 74) begin
			if (rand_bit()) begin
				send_request(OP_RESET, 1'b0, rand_bit(), rand_bit());
			end else begin
				bus_mask = 2'b00;
				send_request(OP_RESET, 1'b1, rand_bit(), rand_bit());
				run_pass(1'b0, ROM_BITS, -1, conflict);
			end
			return;
		end
		good0 = 1'b1;
		good1 = 1'b1;
		if (kind >= 60 && kind < 68) begin
			good0 = rand_bit();
			good1 = rand_bit();
			if (good0 && good1) good1 = 1'b0;
		end
		bus_rom[0] = make_rom(good0);
		bus_rom[1] = make_rom(good1);
		if ($urandom_range(49) == 0) bus_rom[1] = bus_rom[0];
		bus_mask = (kind >= 45 && kind < 60) ? 2'b01 : 2'b11;
		send_request(OP_RESET, 1'b1, rand_bit(), rand_bit());
		run_pass(1'b0,
			(kind >= 82) ? $urandom_range(ROM_BITS - 1) : ROM_BITS,
			(kind >= 74 && kind < 82) ? $urandom_range(ROM_BITS - 1) : -1,
			conflict);
		if (kind >= 74) return;
		// second pass when the first one branched; sometimes even after a
		// rejected id, which the block must refuse
		if (conflict && ((good0 && good1) || $urandom_range(3) == 0)) begin
			if ($urandom_range(19) == 0) begin
				send_request(OP_RESET, 1'b0, rand_bit(), rand_bit());
				return;
			end
			send_request(OP_RESET, 1'b1, rand_bit(), rand_bit());
			run_pass(1'b1, ROM_BITS, -1, conflict);
		end
	endtask

	initial begin
		logic [6:0] fam;
		int         goal;
		arst_n              <= 1'b0;
		family_code_wr_en   <= 1'b0;
		family_code_wr_data <= '0;
		cmd.valid           <= 1'b0;
		cmd.operation       <= OP_START;
		cmd.presence        <= 1'b0;
		cmd.first_bit       <= 1'b0;
		cmd.second_bit      <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: out-of-order requests, the reserved code, each kind of
		// read pair, abort and a restart in the middle of a pass
		send_request(OP_BITS,  1'b0, 1'b0, 1'b1);   // bit pair before any search
		send_request(OP_RESET, 1'b1, 1'b0, 1'b0);   // reset outcome after the end
		send_request(OP_RSVD,  1'b1, 1'b1, 1'b1);
		send_request(OP_START, 1'b0, 1'b0, 1'b0);
		send_request(OP_RESET, 1'b0, 1'b1, 1'b1);   // no presence ends the search
		send_request(OP_RESET, 1'b1, 1'b0, 1'b0);
		send_request(OP_START, 1'b1, 1'b0, 1'b1);
		send_request(OP_RESET, 1'b1, 1'b0, 1'b0);
		send_request(OP_RESET, 1'b1, 1'b1, 1'b1);   // reset outcome inside a pass
		send_request(OP_BITS,  1'b0, 1'b1, 1'b0);
		send_request(OP_BITS,  1'b1, 1'b0, 1'b1);
		send_request(OP_BITS,  1'b0, 1'b0, 1'b0);   // conflict
		send_request(OP_RSVD,  1'b0, 1'b0, 1'b0);
		send_request(OP_BITS,  1'b1, 1'b1, 1'b1);   // both ones abort
		send_request(OP_BITS,  1'b0, 1'b0, 1'b0);
		send_request(OP_START, 1'b1, 1'b1, 1'b1);
		send_request(OP_RESET, 1'b1, 1'b0, 1'b0);
		send_request(OP_BITS,  1'b1, 1'b0, 1'b0);
		send_request(OP_START, 1'b0, 1'b1, 1'b0);   // restart mid pass
		send_request(OP_RESET, 1'b1, 1'b1, 1'b0);
		send_request(OP_BITS,  1'b0, 1'b1, 1'b0);
		cmd.valid <= 1'b0;

		// random phases: no idling, sender idle, receiver stalling, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
					fam           = 7'd127;
				end
				1: begin
					send_idle_pct = 64;
					stall_pct     = 0;
					fam           = 7'($urandom_range(1, 126));
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 64;
					fam           = 7'd0;
				end
				default: begin
					send_idle_pct = 14;
					stall_pct     = 14;
					fam           = 7'($urandom_range(1, 126));
				end
			endcase
			write_family(fam);
			goal = requests_sent + PHASE_REQUESTS;
			while (requests_sent < goal) begin
				// long hold-off once, early in the unthrottled phase
				if (ph == 0 && !holdoff_done && requests_sent > goal - 250) begin
					holdoff_pending = 1'b1;
					holdoff_done    = 1'b1;
				end
				run_random_search();
			end
			cmd.valid <= 1'b0;
		end

		// drain, then allow for the result register latency
		do @(posedge clk); while (results_owed != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("onewire_two_device_rom_search test passed");
		end else begin
			$display("onewire_two_device_rom_search test failed");
		end
		$finish;
	end

endmodule
